>>> src/dsi_pkg.sv
`default_nettype none
package dsi_pkg;

    // ascii codes the parser looks for
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // largest positive int64 magnitude
    localparam logic [63:0] INT64_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // one input transaction
    typedef struct packed {
        logic [7:0] character;
        logic       char_present;
        logic       last_char;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic [63:0] value_bits;
        logic        parse_ok;
    } t_out_item;

    // character class decided by the front
    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_DOT,
        KIND_MINUS,
        KIND_OTHER
    } t_kind;

    // classified character as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       present;
        logic       last;
    } t_cls;

endpackage
`default_nettype wire

>>> src/dsi_front.sv
`default_nettype none
module dsi_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    input  dsi_pkg::t_in_item   i_item,
    input  wire                 i_signed_mode,
    input  wire                 i_queue_full,
    output logic                o_wr,
    output dsi_pkg::t_cls       o_cls
);

    logic is_digit;

    // accept whenever the queue has room
    assign o_wr = push && !i_queue_full;

    // classify the character
    assign is_digit = (i_item.character >= dsi_pkg::CHAR_ZERO) &&
                      (i_item.character <= dsi_pkg::CHAR_NINE);

    always_comb begin
        o_cls.present = i_item.char_present;
        o_cls.last    = i_item.last_char;
        o_cls.digit   = is_digit ? 4'(i_item.character - dsi_pkg::CHAR_ZERO) : 4'd0;
        if (is_digit) begin
            o_cls.kind = dsi_pkg::KIND_DIGIT;
        end else if (i_item.character == dsi_pkg::CHAR_DOT) begin
            o_cls.kind = dsi_pkg::KIND_DOT;
        end else if (i_signed_mode && i_item.character == dsi_pkg::CHAR_MINUS) begin
            // minus is a sign only in signed mode
            o_cls.kind = dsi_pkg::KIND_MINUS;
        end else begin
            o_cls.kind = dsi_pkg::KIND_OTHER;
        end
    end

    // a write never lands on a full queue
    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_queue_full |-> !o_wr)
        else $error("front wrote to a full queue");

endmodule
`default_nettype wire

>>> src/dsi_queue.sv
`default_nettype none
module dsi_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_wr,
    input  dsi_pkg::t_cls   i_wdata,
    output logic            o_full,
    input  wire             i_rd,
    output dsi_pkg::t_cls   o_head,
    output logic            o_empty
);

    dsi_pkg::t_cls                   r_mem [dsi_pkg::QUEUE_DEPTH];
    logic [dsi_pkg::QUEUE_AW-1:0]    r_wp;
    logic [dsi_pkg::QUEUE_AW-1:0]    r_rp;
    logic [dsi_pkg::QUEUE_CW-1:0]    r_cnt;
    logic                            do_wr;
    logic                            do_rd;

    assign o_full  = (r_cnt == dsi_pkg::QUEUE_CW'(dsi_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // fill count stays within depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dsi_pkg::QUEUE_CW'(dsi_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    // the back only reads a filled queue
    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("queue read while empty");

endmodule
`default_nettype wire

>>> src/dsi_back.sv
`default_nettype none
module dsi_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_signed_mode,
    input  dsi_pkg::t_cls       i_head,
    input  wire                 i_head_valid,
    output logic                o_take,
    output dsi_pkg::t_out_item  o_item,
    output logic                empty,
    input  wire                 pop
);

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        fail;
        logic        signed_mode;
    } t_final;

    t_phase              r_phase;
    logic                r_neg;
    logic [63:0]         r_acc;
    logic                r_f_valid;
    t_final              r_f;
    logic                r_o_valid;
    dsi_pkg::t_out_item  r_o;

    t_phase              n_phase;
    logic                n_neg;
    logic [63:0]         n_acc;
    logic [67:0]         prod;
    logic                go_int;
    logic                fin_move;
    logic                fin_free;
    logic                mag_fits;
    logic                fin_ok;
    dsi_pkg::t_out_item  fin_result;

    // handshake between queue head, final stage and output register
    assign fin_move = r_f_valid && (!r_o_valid || pop);
    assign fin_free = !r_f_valid || fin_move;
    assign o_take   = i_head_valid && (!i_head.last || fin_free);
    assign empty    = !r_o_valid;
    assign o_item   = r_o;

    // times ten plus digit as shift-add, carries above bit 63 mean overflow
    assign prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + 68'(i_head.digit);

    // next string state for the head character
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        go_int  = 1'b0;
        if (i_head.present && r_phase != PH_FAIL) begin
            if (r_phase == PH_START) begin
                n_phase = PH_INT;
                if (i_head.kind == dsi_pkg::KIND_MINUS) begin
                    n_neg = 1'b1;
                end
            end
            go_int = (r_phase == PH_INT) ||
                     (r_phase == PH_START && i_head.kind != dsi_pkg::KIND_MINUS);
            if (go_int) begin
                if (i_head.kind == dsi_pkg::KIND_DIGIT) begin
                    if (prod[67:64] != 4'd0) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_acc = prod[63:0];
                    end
                end else if (i_head.kind == dsi_pkg::KIND_DOT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_FAIL;
                end
            end else if (r_phase == PH_FRAC && i_head.kind != dsi_pkg::KIND_DIGIT) begin
                n_phase = PH_FAIL;
            end
        end
    end

    // range check and sign for a finished string
    assign mag_fits = !r_f.acc[63] ||
                      (r_f.neg && r_f.acc == dsi_pkg::INT64_MAG_MAX + 64'd1);
    assign fin_ok   = !r_f.fail && (!r_f.signed_mode || mag_fits);

    always_comb begin
        fin_result.parse_ok = fin_ok;
        if (!fin_ok) begin
            fin_result.value_bits = 64'd0;
        end else if (r_f.signed_mode && r_f.neg) begin
            fin_result.value_bits = 64'd0 - r_f.acc;
        end else begin
            fin_result.value_bits = r_f.acc;
        end
    end

    // string state, final stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_neg     <= 1'b0;
            r_acc     <= 64'd0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (i_head.last) begin
                    r_phase <= PH_START;
                    r_neg   <= 1'b0;
                    r_acc   <= 64'd0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_acc   <= n_acc;
                end
            end
            if (o_take && i_head.last) begin
                r_f_valid       <= 1'b1;
                r_f.acc         <= n_acc;
                r_f.neg         <= n_neg;
                r_f.fail        <= (n_phase == PH_FAIL);
                r_f.signed_mode <= i_signed_mode;
            end else if (fin_move) begin
                r_f_valid <= 1'b0;
            end
            if (fin_move) begin
                r_o_valid <= 1'b1;
                r_o       <= fin_result;
            end else if (pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // a rejected string always reports zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o.parse_ok |-> r_o.value_bits == 64'd0)
        else $error("failed result carries a nonzero value");

    // a waiting result survives a stall unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !pop |=> r_o_valid && $stable(r_o))
        else $error("waiting result lost or changed");

    // string state returns to start after its last character
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && i_head.last |=> r_phase == PH_START && !r_neg && r_acc == 64'd0)
        else $error("string state not cleared after last character");

endmodule
`default_nettype wire

>>> src/decimal_string_to_int64.sv
// Decimal ASCII string to 64-bit integer parser with overflow check.
// Input channel: a queue write port. One character per transaction, taken at a
// rising edge with push high and full low; last_char marks the string's end.
// Result channel: a queue read port. The oldest result sits on o_item while
// empty is low and is taken at a rising edge with pop high.
// Configuration: i_cfg_we writes i_cfg_wdata into signed_mode (reset 1);
// write only while no string is in flight.
// Throughput: one character per cycle, sustained, including one-character
// strings, while the receiver keeps popping results; the multiply by ten is
// a combinational shift-add in the back. A string's result passes the final
// sign and range stage, then the output register, before it is on o_item.
// A 4-entry queue sits between the character classifier and the
// accumulator; the final stage and an output register hold up to two
// results. When the receiver stalls they fill, then the queue fills, and
// full rises; nothing is dropped.
// Reset (synchronous, active low) empties all queues, clears the string
// state and sets signed_mode.
`default_nettype none
module decimal_string_to_int64 (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  dsi_pkg::t_in_item   i_item,
    output logic                empty,
    input  wire                 pop,
    output dsi_pkg::t_out_item  o_item,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata
);

    logic           r_signed_mode;
    logic           wr;
    dsi_pkg::t_cls  wr_cls;
    dsi_pkg::t_cls  head;
    logic           q_empty;
    logic           take;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    // classify incoming characters
    dsi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .i_item        (i_item),
        .i_signed_mode (r_signed_mode),
        .i_queue_full  (full),
        .o_wr          (wr),
        .o_cls         (wr_cls)
    );

    // decoupling queue
    dsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_wdata (wr_cls),
        .o_full  (full),
        .i_rd    (take),
        .o_head  (head),
        .o_empty (q_empty)
    );

    // accumulate and deliver results
    dsi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_signed_mode (r_signed_mode),
        .i_head        (head),
        .i_head_valid  (!q_empty),
        .o_take        (take),
        .o_item        (o_item),
        .empty         (empty),
        .pop           (pop)
    );

endmodule
`default_nettype wire
